### hdl/odm_pkg.sv
// ----------------------------------------------------------------------------
// odm_pkg
// Shared types, codes, reset values and the capped square root function
// for the occupancy distance map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package odm_pkg;

   // default sizes for the top level parameters
   localparam int MAP_W_DEF     = 256;
   localparam int MAP_H_DEF     = 128;
   localparam int GRID_SIZE_DEF = 5;
   localparam int MAX_REACH_DEF = 31;

   // field widths
   localparam int DIST_W     = 5;
   localparam int CMD_W      = 2;
   localparam int POS_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;
   localparam int QUOT_W     = 16;
   localparam int SQ_W       = 14;

   typedef logic [DIST_W-1:0] dist_type;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_HEIGHT = 3'd4;

   // register reset values
   localparam logic [8:0]  RST_MAP_WIDTH   = 9'd256;
   localparam logic [7:0]  RST_MAP_HEIGHT  = 8'd128;
   localparam dist_type    RST_MAX_DIST    = 5'd20;
   localparam logic [14:0] RST_HALF_WIDTH  = 15'd640;
   localparam logic [14:0] RST_HALF_HEIGHT = 15'd320;

   // floor of the square root, capped at 31: counts the squares not above sq
   function automatic dist_type isqrt_cap(input logic [SQ_W-1:0] sq);
      int       k;
      dist_type cnt;
      cnt = '0;
      for (k = 1; k < 32; k++) begin
         if (sq >= SQ_W'(k * k)) begin
            cnt = cnt + dist_type'(1);
         end
      end
      return cnt;
   endfunction

endpackage

### hdl/odm_if.sv
// ----------------------------------------------------------------------------
// odm_if
// Valid/ready channels of the occupancy distance map: request, response and
// register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface odm_req_if;
   logic                                valid;
   logic                                ready;
   logic [odm_pkg::CMD_W-1:0]           cmd;
   logic signed [odm_pkg::POS_W-1:0]    pos_x;
   logic signed [odm_pkg::POS_W-1:0]    pos_y;

   modport source (output valid, cmd, pos_x, pos_y, input ready);
   modport sink   (input valid, cmd, pos_x, pos_y, output ready);
endinterface

interface odm_rsp_if;
   logic                valid;
   logic                ready;
   odm_pkg::dist_type   dist_res;
   logic                is_query;

   modport source (output valid, dist_res, is_query, input ready);
   modport sink   (input valid, dist_res, is_query, output ready);
endinterface

interface odm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [odm_pkg::CSR_IDX_W-1:0]       index;
   logic [odm_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hdl/odm_mem.sv
// ----------------------------------------------------------------------------
// odm_mem
// Distance store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module odm_mem #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  odm_pkg::dist_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output odm_pkg::dist_type rd_data
);

   odm_pkg::dist_type mem_ff [DEPTH];
   odm_pkg::dist_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/odm_div.sv
// ----------------------------------------------------------------------------
// odm_div
// Division by a constant through a reciprocal multiply, the quotient
// registered on start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module odm_div #(
   parameter int DIVISOR = odm_pkg::GRID_SIZE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [odm_pkg::QUOT_W-1:0] dividend,
   output logic                       done,
   output logic [odm_pkg::QUOT_W-1:0] quotient
);

   localparam int QW  = odm_pkg::QUOT_W;
   localparam int SH  = QW + $clog2(DIVISOR);
   localparam int MW  = QW + 2;
   localparam int PRW = QW + MW;
   // ceil(2^SH / DIVISOR) gives the exact floor for every QW-bit dividend
   localparam longint RECIP_L =
      ((longint'(1) << SH) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
   localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

   logic            done_ff;
   logic [QW-1:0]   quot_ff;
   logic [PRW-1:0]  prod;

   // dividend times the scaled reciprocal
   always_comb begin
      prod = PRW'(dividend) * PRW'(RECIP);
   end

   // done is start, registered
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   // quotient is the product shifted down, held until the next start
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= QW'(prod >> SH);
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### hdl/odm_walk.sv
// ----------------------------------------------------------------------------
// odm_walk
// Mark window walker: steps over the square window around a cell and does
// one read-modify-write of the store per cycle through a short pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module odm_walk #(
   parameter int MAP_W     = odm_pkg::MAP_W_DEF,
   parameter int MAP_H     = odm_pkg::MAP_H_DEF,
   parameter int MAX_REACH = odm_pkg::MAX_REACH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [odm_pkg::POS_W-1:0]       center_x,
   input  logic signed [odm_pkg::POS_W-1:0]       center_y,
   input  logic [$clog2(MAX_REACH+1)-1:0]         radius,
   input  logic [$clog2(MAP_W+1)-1:0]             used_w,
   input  logic [$clog2(MAP_H+1)-1:0]             used_h,
   input  odm_pkg::dist_type                      rd_data,
   output logic                                   rd_en,
   output logic [((MAP_W*MAP_H > 1) ? $clog2(MAP_W*MAP_H) : 1)-1:0] rd_addr,
   output logic                                   wr_en,
   output logic [((MAP_W*MAP_H > 1) ? $clog2(MAP_W*MAP_H) : 1)-1:0] wr_addr,
   output odm_pkg::dist_type                      wr_data,
   output logic                                   done
);

   localparam int WW    = $clog2(MAP_W + 1);
   localparam int HW    = $clog2(MAP_H + 1);
   localparam int XW    = (MAP_W > 1) ? $clog2(MAP_W) : 1;
   localparam int YW    = (MAP_H > 1) ? $clog2(MAP_H) : 1;
   localparam int DEPTH = MAP_W * MAP_H;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = $clog2(MAX_REACH + 1);
   localparam int DW    = RW + 1;
   localparam int SQW   = 2 * DW;
   localparam int CW    = odm_pkg::POS_W + 2;
   localparam int PW    = YW + WW;

   // window sequencer
   logic                  run_ff;
   logic signed [DW-1:0]  dx_ff;
   logic signed [DW-1:0]  dy_ff;
   logic signed [DW-1:0]  r_s;
   logic signed [DW-1:0]  r_neg;
   logic                  last_pt;

   // stage a: cell coordinates and squared distance
   logic signed [CW-1:0]  nx;
   logic signed [CW-1:0]  ny;
   logic                  x_in;
   logic                  y_in;
   logic signed [SQW-1:0] dxe;
   logic signed [SQW-1:0] dye;
   logic [SQW-1:0]        sq;
   logic                  a_vld_ff;
   logic                  a_last_ff;
   logic [XW-1:0]         a_nx_ff;
   logic [YW-1:0]         a_ny_ff;
   logic [SQW-1:0]        a_sq_ff;

   // stage b: store address and distance, read issued
   logic [PW-1:0]         prod;
   logic                  b_vld_ff;
   logic                  b_last_ff;
   logic [AW-1:0]         b_addr_ff;
   odm_pkg::dist_type     b_d_ff;

   // stage c: read data back, compare and write
   logic                  c_vld_ff;
   logic                  c_last_ff;
   logic [AW-1:0]         c_addr_ff;
   odm_pkg::dist_type     c_d_ff;

   assign r_s     = $signed({1'b0, radius});
   assign r_neg   = -r_s;
   assign last_pt = (dx_ff == r_s) && (dy_ff == r_s);

   // sequencer: dx outer, dy inner, both from -r to r
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff <= 1'b1;
      end else if (run_ff && last_pt) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dx_ff <= r_neg;
         dy_ff <= r_neg;
      end else if (run_ff) begin
         if (dy_ff == r_s) begin
            dy_ff <= r_neg;
            dx_ff <= dx_ff + DW'(1);
         end else begin
            dy_ff <= dy_ff + DW'(1);
         end
      end
   end

   // cell position, grid check and squared offset
   always_comb begin
      nx   = CW'(center_x) + CW'(dx_ff);
      ny   = CW'(center_y) + CW'(dy_ff);
      x_in = !nx[CW-1] && (nx[CW-2:0] < (CW-1)'(used_w));
      y_in = !ny[CW-1] && (ny[CW-2:0] < (CW-1)'(used_h));
      dxe  = SQW'(dx_ff);
      dye  = SQW'(dy_ff);
      sq   = dxe * dxe + dye * dye;
   end

   // row-major address with the width in use
   assign prod = PW'(a_ny_ff) * PW'(used_w) + PW'(a_nx_ff);

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff  <= 1'b0;
         a_last_ff <= 1'b0;
         b_vld_ff  <= 1'b0;
         b_last_ff <= 1'b0;
         c_vld_ff  <= 1'b0;
         c_last_ff <= 1'b0;
      end else begin
         a_vld_ff  <= run_ff && x_in && y_in;
         a_last_ff <= run_ff && last_pt;
         b_vld_ff  <= a_vld_ff;
         b_last_ff <= a_last_ff;
         c_vld_ff  <= b_vld_ff;
         c_last_ff <= b_last_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      a_nx_ff   <= nx[XW-1:0];
      a_ny_ff   <= ny[YW-1:0];
      a_sq_ff   <= sq;
      b_addr_ff <= prod[AW-1:0];
      b_d_ff    <= odm_pkg::isqrt_cap(odm_pkg::SQ_W'(a_sq_ff));
      c_addr_ff <= b_addr_ff;
      c_d_ff    <= b_d_ff;
   end

   assign rd_en   = b_vld_ff;
   assign rd_addr = b_addr_ff;
   assign wr_en   = c_vld_ff && (c_d_ff < rd_data);
   assign wr_addr = c_addr_ff;
   assign wr_data = c_d_ff;
   assign done    = c_last_ff;

   // cells of one window are distinct, so a write never meets a read of its entry
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("walk write and read hit the same entry");

endmodule

### hdl/occupancy_distance_map.sv
// ----------------------------------------------------------------------------
// occupancy_distance_map
// Grid of capped distances to the nearest marked cell, held in one memory.
//
// Channels: req_chan takes an item (cmd, pos_x, pos_y), rsp_chan gives one
// item (dist_res, is_query) for every request, csr_chan writes the five
// registers (map_width, map_height, max_dist, half_width, half_height) and
// is always ready; write it only while the block is idle.
// One request is worked at a time. Steps from accept to response valid:
//   clear  one store entry written per cycle over all MAP_W*MAP_H entries
//   mark   square window of side 2r+1, r = min(max_dist, MAX_REACH), one read-modify-
//          write per cycle on the store's single read and write port
//   query  the reciprocal multiply by 1/GRID_SIZE, then one store read
//   unused command  a zero response, no store access
// The response sits in an output register; a new request is taken while it
// waits. If the receiver stalls and a second response is ready, the block
// holds it and takes no new request until the first one leaves.
// Reset: registers return to their defaults and the store is swept to 20,
// one entry per cycle, over all MAP_W*MAP_H entries before the first request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module occupancy_distance_map #(
   parameter int MAP_W     = odm_pkg::MAP_W_DEF,
   parameter int MAP_H     = odm_pkg::MAP_H_DEF,
   parameter int GRID_SIZE = odm_pkg::GRID_SIZE_DEF,
   parameter int MAX_REACH = odm_pkg::MAX_REACH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   odm_req_if.sink    req_chan,
   odm_rsp_if.source  rsp_chan,
   odm_csr_if.sink    csr_chan
);

   localparam int WW    = $clog2(MAP_W + 1);
   localparam int HW    = $clog2(MAP_H + 1);
   localparam int XW    = (MAP_W > 1) ? $clog2(MAP_W) : 1;
   localparam int YW    = (MAP_H > 1) ? $clog2(MAP_H) : 1;
   localparam int DEPTH = MAP_W * MAP_H;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = $clog2(MAX_REACH + 1);
   localparam int PW    = YW + WW;
   localparam int QW    = odm_pkg::QUOT_W;
   localparam int SUM_W = odm_pkg::POS_W + 2;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_WALK,
      ST_QSUM,
      ST_QDIV,
      ST_QCHK,
      ST_QREAD,
      ST_QDATA,
      ST_FIN
   } state_type;

   // configuration registers
   logic [8:0]                 map_width_ff;
   logic [7:0]                 map_height_ff;
   odm_pkg::dist_type          max_dist_ff;
   logic [14:0]                half_width_ff;
   logic [14:0]                half_height_ff;

   // control and item registers
   state_type                  state_ff;
   logic [AW-1:0]              sweep_cnt_ff;
   odm_pkg::dist_type          fill_ff;
   logic                       sweep_res_ff;
   logic                       walk_start_ff;
   logic signed [odm_pkg::POS_W-1:0] pos_x_ff;
   logic signed [odm_pkg::POS_W-1:0] pos_y_ff;
   logic signed [SUM_W-1:0]    sum_x_ff;
   logic signed [SUM_W-1:0]    sum_y_ff;
   logic                       okx_ff;
   logic                       oky_ff;
   logic [AW-1:0]              q_addr_ff;
   logic                       q_off_ff;
   odm_pkg::dist_type          res_dist_ff;
   logic                       res_query_ff;
   logic                       rsp_valid_ff;
   odm_pkg::dist_type          rsp_dist_ff;
   logic                       rsp_query_ff;

   // derived values
   logic [WW-1:0]              used_w;
   logic [HW-1:0]              used_h;
   logic [RW-1:0]              radius;
   logic                       div_start;
   logic [QW-1:0]              div_x_in;
   logic [QW-1:0]              div_y_in;
   logic                       div_x_done;
   logic                       div_y_done;
   logic [QW-1:0]              qx;
   logic [QW-1:0]              qy;
   logic                       q_in_grid;
   logic [PW-1:0]              q_prod;
   logic                       sweep_last;

   // walker ports
   logic                       walk_rd_en;
   logic [AW-1:0]              walk_rd_addr;
   logic                       walk_wr_en;
   logic [AW-1:0]              walk_wr_addr;
   odm_pkg::dist_type          walk_wr_data;
   logic                       walk_done;

   // memory ports
   logic                       mem_wr_en;
   logic [AW-1:0]              mem_wr_addr;
   odm_pkg::dist_type          mem_wr_data;
   logic                       mem_rd_en;
   logic [AW-1:0]              mem_rd_addr;
   odm_pkg::dist_type          mem_rd_data;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff   <= odm_pkg::RST_MAP_WIDTH;
         map_height_ff  <= odm_pkg::RST_MAP_HEIGHT;
         max_dist_ff    <= odm_pkg::RST_MAX_DIST;
         half_width_ff  <= odm_pkg::RST_HALF_WIDTH;
         half_height_ff <= odm_pkg::RST_HALF_HEIGHT;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            odm_pkg::CSR_MAP_WIDTH:   map_width_ff   <= csr_chan.data[8:0];
            odm_pkg::CSR_MAP_HEIGHT:  map_height_ff  <= csr_chan.data[7:0];
            odm_pkg::CSR_MAX_DIST:    max_dist_ff    <= csr_chan.data[4:0];
            odm_pkg::CSR_HALF_WIDTH:  half_width_ff  <= csr_chan.data;
            odm_pkg::CSR_HALF_HEIGHT: half_height_ff <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;

   // grid size and radius limited to what the store and walker hold
   assign used_w = (int'(map_width_ff) > MAP_W) ? WW'(MAP_W) : WW'(map_width_ff);
   assign used_h = (int'(map_height_ff) > MAP_H) ? HW'(MAP_H) : HW'(map_height_ff);
   assign radius = (int'(max_dist_ff) > MAX_REACH) ? RW'(MAX_REACH) : RW'(max_dist_ff);

   // query: negative sums divide to zero or fall off the grid
   assign div_start = (state_ff == ST_QSUM);
   assign div_x_in  = sum_x_ff[SUM_W-1] ? '0 : sum_x_ff[QW-1:0];
   assign div_y_in  = sum_y_ff[SUM_W-1] ? '0 : sum_y_ff[QW-1:0];

   odm_div #(
      .DIVISOR (GRID_SIZE)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_x_in),
      .done     (div_x_done),
      .quotient (qx)
   );

   odm_div #(
      .DIVISOR (GRID_SIZE)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_y_in),
      .done     (div_y_done),
      .quotient (qy)
   );

   // query cell check and address
   assign q_in_grid = okx_ff && oky_ff && (qx < QW'(used_w)) && (qy < QW'(used_h));
   assign q_prod    = PW'(qy[YW-1:0]) * PW'(used_w) + PW'(qx[XW-1:0]);

   assign sweep_last = (sweep_cnt_ff == AW'(DEPTH - 1));

   odm_walk #(
      .MAP_W     (MAP_W),
      .MAP_H     (MAP_H),
      .MAX_REACH (MAX_REACH)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .start    (walk_start_ff),
      .center_x (pos_x_ff),
      .center_y (pos_y_ff),
      .radius   (radius),
      .used_w   (used_w),
      .used_h   (used_h),
      .rd_data  (mem_rd_data),
      .rd_en    (walk_rd_en),
      .rd_addr  (walk_rd_addr),
      .wr_en    (walk_wr_en),
      .wr_addr  (walk_wr_addr),
      .wr_data  (walk_wr_data),
      .done     (walk_done)
   );

   // store port sharing between sweep, walker and query
   always_comb begin
      mem_wr_en   = (state_ff == ST_SWEEP) || walk_wr_en;
      mem_wr_addr = (state_ff == ST_SWEEP) ? sweep_cnt_ff : walk_wr_addr;
      mem_wr_data = (state_ff == ST_SWEEP) ? fill_ff : walk_wr_data;
      mem_rd_en   = walk_rd_en || (state_ff == ST_QREAD);
      mem_rd_addr = (state_ff == ST_QREAD) ? q_addr_ff : walk_rd_addr;
   end

   odm_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // command sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_cnt_ff  <= '0;
         fill_ff       <= odm_pkg::RST_MAX_DIST;
         sweep_res_ff  <= 1'b0;
         walk_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         walk_start_ff <= 1'b0;
         // the finish state reloads the register itself
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_SWEEP: begin
               sweep_cnt_ff <= sweep_cnt_ff + AW'(1);
               if (sweep_last) begin
                  res_dist_ff  <= '0;
                  res_query_ff <= 1'b0;
                  state_ff     <= sweep_res_ff ? ST_FIN : ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_chan.valid) begin
                  pos_x_ff <= req_chan.pos_x;
                  pos_y_ff <= req_chan.pos_y;
                  sum_x_ff <= SUM_W'(req_chan.pos_x) + SUM_W'(half_width_ff);
                  sum_y_ff <= SUM_W'(half_height_ff) - SUM_W'(req_chan.pos_y);
                  case (req_chan.cmd)
                     odm_pkg::CMD_CLEAR: begin
                        fill_ff      <= max_dist_ff;
                        sweep_cnt_ff <= '0;
                        sweep_res_ff <= 1'b1;
                        state_ff     <= ST_SWEEP;
                     end
                     odm_pkg::CMD_MARK: begin
                        walk_start_ff <= 1'b1;
                        state_ff      <= ST_WALK;
                     end
                     odm_pkg::CMD_QUERY: begin
                        state_ff <= ST_QSUM;
                     end
                     default: begin
                        res_dist_ff  <= '0;
                        res_query_ff <= 1'b0;
                        state_ff     <= ST_FIN;
                     end
                  endcase
               end
            end
            ST_WALK: begin
               if (walk_done) begin
                  res_dist_ff  <= '0;
                  res_query_ff <= 1'b0;
                  state_ff     <= ST_FIN;
               end
            end
            ST_QSUM: begin
               // truncation toward zero keeps sums above -GRID_SIZE on cell 0
               okx_ff   <= $signed(sum_x_ff + SUM_W'(GRID_SIZE)) > 0;
               oky_ff   <= $signed(sum_y_ff + SUM_W'(GRID_SIZE)) > 0;
               state_ff <= ST_QDIV;
            end
            ST_QDIV: begin
               if (div_x_done && div_y_done) begin
                  state_ff <= ST_QCHK;
               end
            end
            ST_QCHK: begin
               q_addr_ff <= q_prod[AW-1:0];
               q_off_ff  <= !q_in_grid;
               state_ff  <= ST_QREAD;
            end
            ST_QREAD: begin
               state_ff <= ST_QDATA;
            end
            ST_QDATA: begin
               res_dist_ff  <= q_off_ff ? max_dist_ff : mem_rd_data;
               res_query_ff <= 1'b1;
               state_ff     <= ST_FIN;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_dist_ff  <= res_dist_ff;
                  rsp_query_ff <= res_query_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.dist_res = rsp_dist_ff;
   assign rsp_chan.is_query = rsp_query_ff;

   // walker finishes only while a mark is in progress
   a_walk_done_state: assert property (@(posedge clock) disable iff (reset)
      walk_done |-> (state_ff == ST_WALK))
      else $error("walk done outside of a mark");

   // the query read never shares a cycle with a store write
   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QREAD) |-> !mem_wr_en)
      else $error("store write during query read");

   // the walker is quiet while the store is swept
   a_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (!walk_wr_en && !walk_rd_en))
      else $error("walk access during sweep");

   // a response appears only out of the finish state
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("response raised outside finish state");

endmodule
